/* rtl/point_plane_projection_core_macros.svh */
// Assertion helpers for the plane projection core.
`ifndef POINT_PLANE_PROJECTION_CORE_MACROS_SVH
`define POINT_PLANE_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ppp_pkg.sv */
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned CROSS_W   = PROD_W + 1;
  localparam int unsigned MAG_W     = PROD_W;
  localparam int unsigned SHAMT_W   = 7;
  localparam int unsigned NORM_BITS = 30;
  localparam int unsigned NN_W      = NORM_BITS + 2;
  localparam int unsigned NMAG_W    = NORM_BITS + 1;
  localparam int unsigned RAD_W     = 2 * NMAG_W;
  localparam int unsigned ROOT_W    = NMAG_W;
  localparam int unsigned QUO_W     = ROOT_W;
  localparam int unsigned NUM_W     = ROOT_W + NORM_BITS;
  localparam int unsigned TOL_W     = 31;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [NN_W-1:0]    nn_t;

  // Data that rides along the pipeline next to the arithmetic.
  typedef struct packed {
    coord_t [2:0] test;
    diff_t  [2:0] v;
    nn_t    [2:0] nn;
    logic         degen;
  } side_t;

endpackage

/* rtl/ppp_stream_if.sv */
`timescale 1ns / 1ps
interface ppp_in_if;
  import ppp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t base_x;
  coord_t base_y;
  coord_t base_z;
  coord_t side_a_x;
  coord_t side_a_y;
  coord_t side_a_z;
  coord_t test_x;
  coord_t test_y;
  coord_t test_z;
  coord_t side_b_x;
  coord_t side_b_y;
  coord_t side_b_z;

  modport source (
    output valid, base_x, base_y, base_z, side_a_x, side_a_y, side_a_z,
    output test_x, test_y, test_z, side_b_x, side_b_y, side_b_z,
    input  ready
  );
  modport sink (
    input  valid, base_x, base_y, base_z, side_a_x, side_a_y, side_a_z,
    input  test_x, test_y, test_z, side_b_x, side_b_y, side_b_z,
    output ready
  );
endinterface

interface ppp_out_if;
  import ppp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  coord_t signed_distance;
  logic   projected;
  logic   degenerate;

  modport source (
    output valid, out_x, out_y, out_z, signed_distance, projected, degenerate,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, signed_distance, projected, degenerate,
    output ready
  );
endinterface

/* rtl/ppp_isqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module ppp_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ppp_pkg::RAD_W-1:0]   rad_i,
  output logic [ppp_pkg::ROOT_W-1:0]  root_o
);
  import ppp_pkg::*;

  localparam int unsigned ACC_W = RAD_W + 1;

  logic [ACC_W-1:0] x_q [ROOT_W];
  logic [ACC_W-1:0] r_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [ACC_W-1:0] x_in;
    logic [ACC_W-1:0] r_in;
    logic [ACC_W-1:0] bit_c;
    logic [ACC_W-1:0] trial;

    if (s == 0) begin : g_first
      assign x_in = ACC_W'(rad_i);
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[s-1];
      assign r_in = r_q[s-1];
    end

    assign bit_c = ACC_W'(1) << (2 * (ROOT_W - 1 - s));
    assign trial = r_in + bit_c;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_in >= trial) begin
          x_q[s] <= x_in - trial;
          r_q[s] <= (r_in >> 1) + bit_c;
        end else begin
          x_q[s] <= x_in;
          r_q[s] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[ROOT_W-1][ROOT_W-1:0];

endmodule

/* rtl/ppp_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QUO_W bits (num < den * 2^QUO_W).
module ppp_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ppp_pkg::NUM_W-1:0]   num_i,
  input  logic [ppp_pkg::ROOT_W-1:0]  den_i,
  output logic [ppp_pkg::QUO_W-1:0]   quo_o
);
  import ppp_pkg::*;

  logic [NUM_W-1:0]  rem_q [QUO_W];
  logic [ROOT_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0]  quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [NUM_W-1:0]  den_sh;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign den_sh = NUM_W'(den_in) << (QUO_W - 1 - s);
    assign ge     = rem_in >= den_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_in - den_sh : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

/* rtl/point_plane_projection_core.sv */
`timescale 1ns / 1ps
// Channel   | Dir | Handshake      | Word
// ----------+-----+----------------+--------------------------------------------
// in_i      | in  | valid / ready  | base, side_a, test, side_b corners (x,y,z)
// out_o     | out | valid / ready  | out_x/y/z, signed_distance, flags
// cfg       | in  | cfg_we_i       | plane_tolerance, unsigned Q31.0, 31 bit
//
// Fully pipelined: one word accepted per cycle while the pipe is not
// stalled. Depth is set mostly by the 31-stage square root and the 31-stage
// unit-normal divider, one result bit per stage each.
// Reset (async, active low) clears valid bits and sets the tolerance to 1.
// Stalls freeze the whole pipe: it advances when the output register is
// empty or being taken, so no word is lost or repeated.
`include "point_plane_projection_core_macros.svh"

module point_plane_projection_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ppp_pkg::TOL_W-1:0] cfg_data_i,
  ppp_in_if.sink                    in_i,
  ppp_out_if.source                 out_o
);
  import ppp_pkg::*;

  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned UV_W   = NN_W + DIFF_W;        // u * v
  localparam int unsigned DOT_W  = UV_W + 2;             // sum of three
  localparam int unsigned D_W    = DOT_W - NORM_BITS;    // distance before sat
  localparam int unsigned SPLIT  = 18;                   // d split for d*u
  localparam int unsigned HI_W   = D_W - SPLIT;
  localparam int unsigned PL_W   = SPLIT + 1 + NN_W;
  localparam int unsigned PP_W   = PL_W + SPLIT + 1;
  localparam int unsigned CORR_W = PP_W - NORM_BITS;
  localparam int unsigned SAT_W  = CORR_W + 1;

  localparam logic signed [DOT_W-1:0] DOT_RND = DOT_W'(1) << (NORM_BITS - 1);
  localparam logic signed [PP_W-1:0]  PP_RND  = PP_W'(1) << (NORM_BITS - 1);

  // Clamp to the signed coordinate range.
  function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-COORD_W:0] top;
    top = x[SAT_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return x[COORD_W-1:0];
    end else if (x[SAT_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end
    return {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  function automatic logic [NMAG_W-1:0] nn_mag(input nn_t x);
    nn_t t;
    t = (x < 0) ? -x : x;
    return t[NMAG_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Control: one stall enable for every stage.
  // ---------------------------------------------------------------------
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  coord_t p0 [3];
  coord_t p1 [3];
  coord_t p2 [3];
  coord_t p3 [3];

  always_comb begin
    p0[0] = in_i.base_x;   p0[1] = in_i.base_y;   p0[2] = in_i.base_z;
    p1[0] = in_i.side_a_x; p1[1] = in_i.side_a_y; p1[2] = in_i.side_a_z;
    p2[0] = in_i.test_x;   p2[1] = in_i.test_y;   p2[2] = in_i.test_z;
    p3[0] = in_i.side_b_x; p3[1] = in_i.side_b_y; p3[2] = in_i.side_b_z;
  end

  // ---------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic s7_vld_q, s8_vld_q, sn_vld_q, su_vld_q;
  logic d1_vld_q, d2_vld_q, d3_vld_q, d4_vld_q;
  logic [SQRT_STEPS-1:0] sq_vld_q;
  logic [DIV_STEPS-1:0]  dv_vld_q;

  side_t s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q, s6_side_q;
  side_t s7_side_q, s8_side_q, sn_side_q, su_side_q;
  side_t d1_side_q, d2_side_q, d3_side_q, d4_side_q;
  side_t sq_side_q [SQRT_STEPS];
  side_t dv_side_q [DIV_STEPS];
  side_t s1_side_d, s5_side_d, s6_side_d;

  diff_t                     s1_a_q [3];
  diff_t                     s1_b_q [3];
  logic signed [PROD_W-1:0]  s2_pr_q [6];
  logic signed [CROSS_W-1:0] s3_n_q [3];
  logic signed [CROSS_W-1:0] s4_n_q [3];
  logic [MAG_W-1:0]          s4_or_q;
  logic signed [CROSS_W-1:0] s5_n_q [3];
  logic [SHAMT_W-1:0]        s5_m_q;
  logic [RAD_W-1:0]          s7_sq_q [3];
  logic [RAD_W-1:0]          s8_q_q;
  logic [NUM_W-1:0]          sn_num_q [3];
  logic [ROOT_W-1:0]         sn_den_q;
  nn_t                       su_u_q [3];
  logic signed [UV_W-1:0]    d1_pu_q [3];
  nn_t                       d1_u_q [3];
  logic signed [D_W-1:0]     d2_d_q;
  nn_t                       d2_u_q [3];
  logic signed [PL_W-1:0]    d3_plo_q [3];
  logic signed [PL_W-1:0]    d3_phi_q [3];
  logic                      d3_chg_q;
  coord_t                    d3_dist_q;
  logic signed [CORR_W-1:0]  d4_corr_q [3];
  logic                      d4_chg_q;
  coord_t                    d4_dist_q;

  coord_t out_x_q, out_y_q, out_z_q, out_dist_q;
  logic   out_chg_q, out_degen_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0; s2_vld_q <= 1'b0; s3_vld_q <= 1'b0; s4_vld_q <= 1'b0;
      s5_vld_q  <= 1'b0; s6_vld_q <= 1'b0; s7_vld_q <= 1'b0; s8_vld_q <= 1'b0;
      sq_vld_q  <= '0;   sn_vld_q <= 1'b0; dv_vld_q <= '0;   su_vld_q <= 1'b0;
      d1_vld_q  <= 1'b0; d2_vld_q <= 1'b0; d3_vld_q <= 1'b0; d4_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      sq_vld_q  <= {sq_vld_q[SQRT_STEPS-2:0], s8_vld_q};
      sn_vld_q  <= sq_vld_q[SQRT_STEPS-1];
      dv_vld_q  <= {dv_vld_q[DIV_STEPS-2:0], sn_vld_q};
      su_vld_q  <= dv_vld_q[DIV_STEPS-1];
      d1_vld_q  <= su_vld_q;
      d2_vld_q  <= d1_vld_q;
      d3_vld_q  <= d2_vld_q;
      d4_vld_q  <= d3_vld_q;
      out_vld_q <= d4_vld_q;
    end
  end

  // ---------------------------------------------------------------------
  // Normal: differences, cross product, bit length, normalize to 30 bits.
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0] or_d;
  logic [SHAMT_W-1:0] blen;
  nn_t nn_d [3];

  always_comb begin
    logic signed [CROSS_W-1:0] mg;
    or_d = '0;
    for (int i = 0; i < 3; i++) begin
      mg   = (s3_n_q[i] < 0) ? -s3_n_q[i] : s3_n_q[i];
      or_d = or_d | mg[MAG_W-1:0];
    end
  end

  // Bit length of the OR of magnitudes equals that of the largest one.
  always_comb begin
    blen = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (s4_or_q[k]) begin
        blen = SHAMT_W'(k + 1);
      end
    end
  end

  always_comb begin
    logic signed [CROSS_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (s5_m_q > SHAMT_W'(NORM_BITS)) begin
        sh = s5_n_q[i] >>> (s5_m_q - SHAMT_W'(NORM_BITS));
      end else begin
        sh = s5_n_q[i] <<< (SHAMT_W'(NORM_BITS) - s5_m_q);
      end
      nn_d[i] = sh[NN_W-1:0];
    end
  end

  // Side data entering S1, S5 and S6
  always_comb begin
    s1_side_d = '0;
    for (int i = 0; i < 3; i++) begin
      s1_side_d.test[i] = p2[i];
      s1_side_d.v[i]    = DIFF_W'(p2[i]) - DIFF_W'(p0[i]);
    end
    // zero normal means collinear corners
    s5_side_d       = s4_side_q;
    s5_side_d.degen = (s4_or_q == '0);
    s6_side_d       = s5_side_q;
    for (int i = 0; i < 3; i++) begin
      s6_side_d.nn[i] = nn_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // S1: edge vectors
      for (int i = 0; i < 3; i++) begin
        s1_a_q[i] <= DIFF_W'(p1[i]) - DIFF_W'(p0[i]);
        s1_b_q[i] <= DIFF_W'(p3[i]) - DIFF_W'(p0[i]);
      end
      s1_side_q <= s1_side_d;

      // S2: cross product terms
      s2_pr_q[0] <= s1_a_q[1] * s1_b_q[2];
      s2_pr_q[1] <= s1_a_q[2] * s1_b_q[1];
      s2_pr_q[2] <= s1_a_q[2] * s1_b_q[0];
      s2_pr_q[3] <= s1_a_q[0] * s1_b_q[2];
      s2_pr_q[4] <= s1_a_q[0] * s1_b_q[1];
      s2_pr_q[5] <= s1_a_q[1] * s1_b_q[0];
      s2_side_q  <= s1_side_q;

      // S3: exact normal
      for (int i = 0; i < 3; i++) begin
        s3_n_q[i] <= CROSS_W'(s2_pr_q[2*i]) - CROSS_W'(s2_pr_q[2*i+1]);
      end
      s3_side_q <= s2_side_q;

      // S4: magnitude OR
      s4_n_q    <= s3_n_q;
      s4_or_q   <= or_d;
      s4_side_q <= s3_side_q;

      // S5: bit length and degenerate flag
      s5_n_q    <= s4_n_q;
      s5_m_q    <= blen;
      s5_side_q <= s5_side_d;

      // S6: normalized normal
      s6_side_q <= s6_side_d;

      // S7: squares
      for (int i = 0; i < 3; i++) begin
        s7_sq_q[i] <= RAD_W'(nn_mag($signed(s6_side_q.nn[i])))
                    * RAD_W'(nn_mag($signed(s6_side_q.nn[i])));
      end
      s7_side_q <= s6_side_q;

      // S8: squared length
      s8_q_q    <= s7_sq_q[0] + s7_sq_q[1] + s7_sq_q[2];
      s8_side_q <= s7_side_q;

      // Side data alongside the root pipeline
      sq_side_q[0] <= s8_side_q;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Length and unit normal
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quo [3];

  ppp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s8_q_q),
    .root_o (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    ppp_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (sn_num_q[i]),
      .den_i (sn_den_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Numerator |n'| * 2^30 + L/2 rounds the quotient half away from zero.
      for (int i = 0; i < 3; i++) begin
        sn_num_q[i] <= NUM_W'({nn_mag($signed(sq_side_q[SQRT_STEPS-1].nn[i])),
                               {NORM_BITS{1'b0}}}) + NUM_W'(root >> 1);
      end
      sn_den_q  <= root;
      sn_side_q <= sq_side_q[SQRT_STEPS-1];

      dv_side_q[0] <= sn_side_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end

      // Signed unit normal, Q2.30
      for (int i = 0; i < 3; i++) begin
        su_u_q[i] <= ($signed(dv_side_q[DIV_STEPS-1].nn[i]) < 0)
                   ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end
      su_side_q <= dv_side_q[DIV_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------
  // Distance and projection
  // ---------------------------------------------------------------------
  logic signed [DOT_W-1:0]  dot;
  logic signed [D_W-1:0]    d_mag;
  logic signed [PP_W-1:0]   pp [3];
  logic signed [SAT_W-1:0]  res [3];

  assign dot = DOT_W'(d1_pu_q[0]) + DOT_W'(d1_pu_q[1]) + DOT_W'(d1_pu_q[2]) + DOT_RND;
  assign d_mag = (d2_d_q < 0) ? -d2_d_q : d2_d_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp[i]  = (PP_W'(d3_phi_q[i]) <<< SPLIT) + PP_W'(d3_plo_q[i]) + PP_RND;
      res[i] = SAT_W'($signed(d4_side_q.test[i])) - SAT_W'(d4_corr_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // D1: u . v terms
      for (int i = 0; i < 3; i++) begin
        d1_pu_q[i] <= su_u_q[i] * $signed(su_side_q.v[i]);
      end
      d1_u_q    <= su_u_q;
      d1_side_q <= su_side_q;

      // D2: rounded distance
      d2_d_q    <= dot[DOT_W-1:NORM_BITS];
      d2_u_q    <= d1_u_q;
      d2_side_q <= d1_side_q;

      // D3: threshold and split d * u
      d3_chg_q  <= $unsigned(d_mag) >= D_W'(tol_q);
      d3_dist_q <= sat_coord(SAT_W'(d2_d_q));
      for (int i = 0; i < 3; i++) begin
        d3_plo_q[i] <= $signed({1'b0, d2_d_q[SPLIT-1:0]}) * d2_u_q[i];
        d3_phi_q[i] <= $signed(d2_d_q[D_W-1:SPLIT]) * d2_u_q[i];
      end
      d3_side_q <= d2_side_q;

      // D4: rounded correction along the normal
      for (int i = 0; i < 3; i++) begin
        d4_corr_q[i] <= pp[i][PP_W-1:NORM_BITS];
      end
      d4_chg_q  <= d3_chg_q;
      d4_dist_q <= d3_dist_q;
      d4_side_q <= d3_side_q;

      // Output register
      if (d4_side_q.degen) begin
        out_x_q    <= d4_side_q.test[0];
        out_y_q    <= d4_side_q.test[1];
        out_z_q    <= d4_side_q.test[2];
        out_dist_q <= '0;
        out_chg_q  <= 1'b0;
      end else if (d4_chg_q) begin
        out_x_q    <= sat_coord(res[0]);
        out_y_q    <= sat_coord(res[1]);
        out_z_q    <= sat_coord(res[2]);
        out_dist_q <= d4_dist_q;
        out_chg_q  <= 1'b1;
      end else begin
        out_x_q    <= d4_side_q.test[0];
        out_y_q    <= d4_side_q.test[1];
        out_z_q    <= d4_side_q.test[2];
        out_dist_q <= d4_dist_q;
        out_chg_q  <= 1'b0;
      end
      out_degen_q <= d4_side_q.degen;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.out_x           = out_x_q;
  assign out_o.out_y           = out_y_q;
  assign out_o.out_z           = out_z_q;
  assign out_o.signed_distance = out_dist_q;
  assign out_o.projected       = out_chg_q;
  assign out_o.degenerate      = out_degen_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PPP_ASSERT_IMP(a_degen_untouched, clk_i, rst_ni, out_o.valid && out_o.degenerate, !out_o.projected && (out_o.signed_distance == '0))
  `PPP_ASSERT_NXT(a_stall_freezes, clk_i, rst_ni, !en, $stable(sq_vld_q) && $stable(dv_vld_q))
  `PPP_ASSERT_IMP(a_len_normalized, clk_i, rst_ni, sn_vld_q && !sn_side_q.degen, sn_den_q[ROOT_W-1:ROOT_W-2] != 2'b00)

endmodule
